// ===== rtl/core/rsbk_pkg.sv =====
package rsbk_pkg;

    localparam int MAX_RECORDS = 64;
    localparam int IDX_W       = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
    localparam int PRICE_W     = 32;
    localparam int DATE_W      = 23;
    localparam int REC_W       = PRICE_W + DATE_W;

    typedef struct packed {
        logic [PRICE_W-1:0] price_key;
        logic [DATE_W-1:0]  date_tag;
        logic               last_record;
    } rsbk_in_t;

    typedef struct packed {
        logic [PRICE_W-1:0] sorted_price;
        logic [DATE_W-1:0]  sorted_date;
        logic               end_of_set;
    } rsbk_out_t;

    // one stored record, as held in the record memory
    typedef struct packed {
        logic [PRICE_W-1:0] key;
        logic [DATE_W-1:0]  payload;
    } rsbk_rec_t;

    typedef struct packed {
        logic load;
        logic last;
    } rsbk_emit_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SORT_START,
        ST_SORT_FIRST,
        ST_SORT_RUN,
        ST_SORT_TAIL,
        ST_EMIT_RD,
        ST_EMIT_LD
    } rsbk_state_t;

endpackage

// ===== rtl/core/record_sort_by_key.sv =====
// Stable ascending sort of up to MAX_RECORDS price/date records. Records load one per
// cycle while rec_ready is high into a single record memory until a transaction flagged
// last_record; records past capacity are dropped. The set is then sorted in place by
// bubble passes, one memory read and one write per cycle in the body of a pass,
// carrying the larger record to the right; equal prices keep their load order, and a
// pass without a swap ends the sort. Each record is then emitted by a memory read and
// a load of the output register, waiting while the output is held, with end_of_set on
// the final one.
// Loading of the next set may begin while the final result still waits.
module record_sort_by_key (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rec_valid,
    output logic                 rec_ready,
    input  rsbk_pkg::rsbk_in_t   rec_data,
    output logic                 srt_valid,
    input  logic                 srt_ready,
    output rsbk_pkg::rsbk_out_t  srt_data
);

    logic                         srt_valid_reg;
    rsbk_pkg::rsbk_out_t          srt_data_reg;
    rsbk_pkg::rsbk_emit_t         emit;
    logic                         mem_we;
    logic [rsbk_pkg::IDX_W-1:0]   mem_waddr;
    rsbk_pkg::rsbk_rec_t          mem_wdata;
    logic                         mem_re;
    logic [rsbk_pkg::IDX_W-1:0]   mem_raddr;
    rsbk_pkg::rsbk_rec_t          mem_rdata;
    logic                         out_free;

    assign out_free = !srt_valid_reg || srt_ready;

    rsbk_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec_data  (rec_data),
        .out_free  (out_free),
        .emit      (emit),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    rsbk_ram #(
        .DATA_W (rsbk_pkg::REC_W),
        .DEPTH  (rsbk_pkg::MAX_RECORDS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            srt_valid_reg <= 1'b0;
        end
        else if (emit.load)
        begin
            srt_valid_reg <= 1'b1;
        end
        else if (srt_ready)
        begin
            srt_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.load)
        begin
            srt_data_reg <= '{sorted_price: mem_rdata.key,
                              sorted_date:  mem_rdata.payload,
                              end_of_set:   emit.last};
        end
    end

    assign srt_valid = srt_valid_reg;
    assign srt_data  = srt_data_reg;

endmodule

// ===== rtl/core/rsbk_ram.sv =====
module rsbk_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/rsbk_ctrl.sv =====
module rsbk_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rec_valid,
    output logic                         rec_ready,
    input  rsbk_pkg::rsbk_in_t           rec_data,
    input  logic                         out_free,
    output rsbk_pkg::rsbk_emit_t         emit,
    output logic                         mem_we,
    output logic [rsbk_pkg::IDX_W-1:0]   mem_waddr,
    output rsbk_pkg::rsbk_rec_t          mem_wdata,
    output logic                         mem_re,
    output logic [rsbk_pkg::IDX_W-1:0]   mem_raddr,
    input  rsbk_pkg::rsbk_rec_t          mem_rdata
);

    localparam int IDX_W = rsbk_pkg::IDX_W;
    localparam int CNT_W = rsbk_pkg::CNT_W;

    rsbk_pkg::rsbk_state_t state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      pass_len_reg, pass_len_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic                  swapped_reg, swapped_next;
    rsbk_pkg::rsbk_rec_t   carry_reg, carry_next;

    logic                  room;
    logic                  gt;
    logic [CNT_W-1:0]      stored_cnt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rsbk_pkg::ST_LOAD;
            count_reg    <= '0;
            pass_len_reg <= '0;
            idx_reg      <= '0;
            swapped_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            pass_len_reg <= pass_len_next;
            idx_reg      <= idx_next;
            swapped_reg  <= swapped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
    end

    assign room       = (count_reg < CNT_W'(rsbk_pkg::MAX_RECORDS));
    assign gt         = (carry_reg.key > mem_rdata.key);
    assign stored_cnt = count_reg + CNT_W'(room);
    assign rec_ready  = (state_reg == rsbk_pkg::ST_LOAD);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        pass_len_next = pass_len_reg;
        idx_next      = idx_reg;
        swapped_next  = swapped_reg;
        carry_next    = carry_reg;
        mem_we        = 1'b0;
        mem_waddr     = count_reg[IDX_W-1:0];
        mem_wdata     = '{key: rec_data.price_key, payload: rec_data.date_tag};
        mem_re        = 1'b0;
        mem_raddr     = idx_reg;
        emit          = '{load: 1'b0, last: 1'b0};

        case (state_reg)
            rsbk_pkg::ST_LOAD:
            begin
                if (rec_valid)
                begin
                    // drop the record once the store is full
                    mem_we     = room;
                    count_next = stored_cnt;
                    if (rec_data.last_record)
                    begin
                        pass_len_next = stored_cnt;
                        idx_next      = '0;
                        if (stored_cnt >= CNT_W'(2))
                        begin
                            state_next = rsbk_pkg::ST_SORT_START;
                        end
                        else
                        begin
                            state_next = rsbk_pkg::ST_EMIT_RD;
                        end
                    end
                end
            end

            rsbk_pkg::ST_SORT_START:
            begin
                mem_re       = 1'b1;
                mem_raddr    = '0;
                idx_next     = IDX_W'(1);
                swapped_next = 1'b0;
                state_next   = rsbk_pkg::ST_SORT_FIRST;
            end

            rsbk_pkg::ST_SORT_FIRST:
            begin
                carry_next = mem_rdata;
                mem_re     = 1'b1;
                mem_raddr  = idx_reg;
                state_next = rsbk_pkg::ST_SORT_RUN;
            end

            rsbk_pkg::ST_SORT_RUN:
            begin
                // carry holds the largest record of the pass so far; it sinks right
                mem_we    = 1'b1;
                mem_waddr = idx_reg - IDX_W'(1);
                mem_wdata = gt ? mem_rdata : carry_reg;
                carry_next = gt ? carry_reg : mem_rdata;
                if (gt)
                begin
                    swapped_next = 1'b1;
                end
                if (CNT_W'(idx_reg) == pass_len_reg - CNT_W'(1))
                begin
                    state_next = rsbk_pkg::ST_SORT_TAIL;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = idx_reg + IDX_W'(1);
                    idx_next   = idx_reg + IDX_W'(1);
                end
            end

            rsbk_pkg::ST_SORT_TAIL:
            begin
                mem_we    = 1'b1;
                mem_waddr = IDX_W'(pass_len_reg - CNT_W'(1));
                mem_wdata = carry_reg;
                if (swapped_reg && (pass_len_reg > CNT_W'(2)))
                begin
                    pass_len_next = pass_len_reg - CNT_W'(1);
                    state_next    = rsbk_pkg::ST_SORT_START;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = rsbk_pkg::ST_EMIT_RD;
                end
            end

            rsbk_pkg::ST_EMIT_RD:
            begin
                if (out_free)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = idx_reg;
                    state_next = rsbk_pkg::ST_EMIT_LD;
                end
            end

            rsbk_pkg::ST_EMIT_LD:
            begin
                emit.load = 1'b1;
                emit.last = (CNT_W'(idx_reg) == count_reg - CNT_W'(1));
                if (emit.last)
                begin
                    count_next = '0;
                    idx_next   = '0;
                    state_next = rsbk_pkg::ST_LOAD;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = rsbk_pkg::ST_EMIT_RD;
                end
            end

            default:
            begin
                state_next = rsbk_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

// ===== rtl/core/rsbk_check.sv =====
module rsbk_check (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rec_valid,
    input  logic                 rec_ready,
    input  rsbk_pkg::rsbk_in_t   rec_data,
    input  logic                 srt_valid,
    input  logic                 srt_ready,
    input  rsbk_pkg::rsbk_out_t  srt_data
);

    logic                         mid_set_reg;
    logic [rsbk_pkg::PRICE_W-1:0] prev_price_reg;
    logic                         srt_xfer;

    assign srt_xfer = srt_valid && srt_ready;

    // track the price of the previous result within the current set
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_set_reg <= 1'b0;
        end
        else if (srt_xfer)
        begin
            mid_set_reg <= !srt_data.end_of_set;
        end
    end

    always_ff @(posedge clk)
    begin
        if (srt_xfer)
        begin
            prev_price_reg <= srt_data.sorted_price;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        srt_valid && !srt_ready |=> srt_valid && $stable(srt_data))
        else $error("result changed while stalled");

    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        srt_xfer && mid_set_reg |-> srt_data.sorted_price >= prev_price_reg)
        else $error("results out of ascending price order");

    a_last_stops_load: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && rec_ready && rec_data.last_record |=> !rec_ready)
        else $error("load continued after last record");

    a_no_load_mid_emit: assert property (@(posedge clk) disable iff (!rst_n)
        srt_valid && !srt_data.end_of_set |-> !rec_ready)
        else $error("load accepted while a set is being emitted");

endmodule

bind record_sort_by_key rsbk_check u_rsbk_check (.*);
